FILE: rtl/core/pdga_pkg.sv
package pdga_pkg;

  // Default sizes of the grid store and of the candidate coordinates.
  // GRID_CELLS is a power of two: a cell number wraps on the low address bits.
  localparam int GRID_CELLS_DEF = 4096;
  localparam int COORD_BITS_DEF = 20;

  // Field widths
  localparam int PT_W       = 19;  // stored coordinate, unsigned Q11.8
  localparam int INV_W      = 24;  // reciprocal cell size
  localparam int INV_SHIFT  = 24;  // cell = (coord * inv) >> 24
  localparam int DIM_W      = 13;  // grid columns / rows
  localparam int DIST_W     = 40;  // squared distance
  localparam int CNT_W      = 13;
  localparam int OUT_IDX_W  = 12;
  localparam int STATUS_W   = 2;
  localparam int ENTRY_W    = 2 * PT_W + 1;  // {valid, y, x}

  // Shared multiplier
  localparam int MUL_A_W = PT_W;
  localparam int MUL_B_W = INV_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Neighborhood: offsets -2 .. 2 on each axis
  localparam int NBR_RADIUS = 2;
  localparam int NBR_SPAN   = 2 * NBR_RADIUS + 1;
  localparam int NBR_W      = 3;

  localparam logic [CNT_W-1:0]     CNT_MAX   = 13'd8191;
  localparam logic [OUT_IDX_W-1:0] SHOWN_MAX = 12'd4095;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_CLOSE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_SQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd5;

  localparam logic [PT_W-1:0]   RECT_RESET = 19'd524287;
  localparam logic [INV_W-1:0]  INV_RESET  = 24'd65536;
  localparam logic [DIM_W-1:0]  DIM_RESET  = 13'd64;

endpackage

FILE: rtl/core/poisson_disk_grid_acceptor.sv
// Channel   Handshake        Payload
// command   start / busy     kind, cand_x, cand_y
// result    strobe           status, point_index, cell_index
// config    wr_en            wr_index, wr_data
//
// A candidate outside the rectangle raises strobe directly from S_RANGE, the state after S_IDLE.
// An accepted candidate passes the setup states S_RANGE, S_CX, S_CY, S_OWNM and
// S_OWNA, then S_ROW and S_RB per neighbor row, S_RD and S_DX per neighbor cell plus
// S_DY and S_CMP when the cell holds a point, and the write in S_WR; a too-close
// candidate stops at the first close neighbor. The single multiplier (two squares per
// stored neighbor) and the single-port grid memory set this sequence.
// A clear item, and rst, sweep the grid memory one cell a cycle with busy high.
// The result strobe lasts one cycle and cannot stall.
module poisson_disk_grid_acceptor #(
  parameter int GRID_CELLS = pdga_pkg::GRID_CELLS_DEF,
  parameter int COORD_BITS = pdga_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic signed [COORD_BITS-1:0]        cand_x,
  input  logic signed [COORD_BITS-1:0]        cand_y,
  input  logic                                wr_en,
  input  logic [pdga_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [pdga_pkg::CFG_DATA_W-1:0]     wr_data,
  output logic                                strobe,
  output logic [pdga_pkg::STATUS_W-1:0]       status,
  output logic [pdga_pkg::OUT_IDX_W-1:0]      point_index,
  output logic [pdga_pkg::OUT_IDX_W-1:0]      cell_index
);

  localparam int IDX_W = $clog2(GRID_CELLS);
  localparam int CMP_W = (COORD_BITS > pdga_pkg::PT_W ? COORD_BITS : pdga_pkg::PT_W) + 1;
  localparam int OFS_W = pdga_pkg::DIM_W + 2;
  localparam int PT_W  = pdga_pkg::PT_W;
  localparam int DIM_W = pdga_pkg::DIM_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_RANGE = 4'd2;
  localparam logic [3:0] S_CX    = 4'd3;
  localparam logic [3:0] S_CY    = 4'd4;
  localparam logic [3:0] S_OWNM  = 4'd5;
  localparam logic [3:0] S_OWNA  = 4'd6;
  localparam logic [3:0] S_ROW   = 4'd7;
  localparam logic [3:0] S_RB    = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;
  localparam logic [3:0] S_DX    = 4'd10;
  localparam logic [3:0] S_DY    = 4'd11;
  localparam logic [3:0] S_CMP   = 4'd12;
  localparam logic [3:0] S_WR    = 4'd13;

  localparam logic [pdga_pkg::NBR_W-1:0] NBR_LAST = pdga_pkg::NBR_W'(pdga_pkg::NBR_SPAN - 1);

  // configuration
  logic [PT_W-1:0]                  rect_width;
  logic [PT_W-1:0]                  rect_height;
  logic [pdga_pkg::DIST_W-1:0]      min_dist_sq;
  logic [pdga_pkg::INV_W-1:0]       inv_cell_size;
  logic [DIM_W-1:0]                 grid_cols;
  logic [DIM_W-1:0]                 grid_rows;

  // sequencer and working registers
  logic [3:0]                       state;
  logic [IDX_W-1:0]                 clr_addr;
  logic                             clr_report;
  logic [COORD_BITS-1:0]            x_raw;
  logic [COORD_BITS-1:0]            y_raw;
  logic [DIM_W-1:0]                 cx;
  logic [DIM_W-1:0]                 cy;
  logic [IDX_W-1:0]                 own;
  logic [pdga_pkg::NBR_W-1:0]       row;
  logic [pdga_pkg::NBR_W-1:0]       col;
  logic [IDX_W-1:0]                 rowbase;
  logic [PT_W-1:0]                  ady;
  logic [2*PT_W-1:0]                sq_x;
  logic [pdga_pkg::CNT_W-1:0]       count;

  // datapath
  logic [COORD_BITS-2:0]            x_mag;
  logic [COORD_BITS-2:0]            y_mag;
  logic                             outside;
  logic [PT_W-1:0]                  px;
  logic [PT_W-1:0]                  py;
  logic [DIM_W-1:0]                 cols_eff;
  logic [DIM_W-1:0]                 rows_eff;
  logic [DIM_W-1:0]                 cols_m1;
  logic [DIM_W-1:0]                 rows_m1;
  logic [PT_W-1:0]                  q;
  logic [DIM_W-1:0]                 q_col;
  logic [DIM_W-1:0]                 q_row;
  logic signed [OFS_W-1:0]          nx_s;
  logic signed [OFS_W-1:0]          ny_s;
  logic [DIM_W-1:0]                 nx;
  logic [DIM_W-1:0]                 ny;
  logic [IDX_W-1:0]                 nbr_addr;
  logic [pdga_pkg::OUT_IDX_W-1:0]   shown;
  logic                             last_cell;

  logic                             mul_en;
  logic [pdga_pkg::MUL_A_W-1:0]     mul_a;
  logic [pdga_pkg::MUL_B_W-1:0]     mul_b;
  logic [pdga_pkg::PROD_W-1:0]      prod;

  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_addr;
  logic [pdga_pkg::ENTRY_W-1:0]     mem_wdata;
  logic [pdga_pkg::ENTRY_W-1:0]     mem_rdata;
  logic                             nbr_valid;
  logic [PT_W-1:0]                  sx;
  logic [PT_W-1:0]                  sy;
  logic [PT_W-1:0]                  adx;
  logic [PT_W-1:0]                  ady_c;
  logic [pdga_pkg::DIST_W-1:0]      dist_sum;

  pdga_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pdga_grid_mem #(
    .DEPTH  (GRID_CELLS),
    .ADDR_W (IDX_W)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy = rst | (state != S_IDLE);

  // range check on the latched candidate
  assign x_mag   = x_raw[COORD_BITS-2:0];
  assign y_mag   = y_raw[COORD_BITS-2:0];
  assign outside = x_raw[COORD_BITS-1] | y_raw[COORD_BITS-1]
                 | (CMP_W'(x_mag) > CMP_W'(rect_width))
                 | (CMP_W'(y_mag) > CMP_W'(rect_height));
  // an inside coordinate never exceeds 19 bits
  assign px = PT_W'(x_mag);
  assign py = PT_W'(y_mag);

  assign cols_eff = (grid_cols == '0) ? DIM_W'(1) : grid_cols;
  assign rows_eff = (grid_rows == '0) ? DIM_W'(1) : grid_rows;
  assign cols_m1  = cols_eff - DIM_W'(1);
  assign rows_m1  = rows_eff - DIM_W'(1);

  // cell coordinate from the registered product, clamped to the grid
  assign q     = prod[pdga_pkg::INV_SHIFT +: PT_W];
  assign q_col = (q > PT_W'(cols_m1)) ? cols_m1 : DIM_W'(q);
  assign q_row = (q > PT_W'(rows_m1)) ? rows_m1 : DIM_W'(q);

  // neighbor cell, clamped to the grid
  assign nx_s = signed'({2'b00, cx}) + signed'(OFS_W'(col))
              - signed'(OFS_W'(pdga_pkg::NBR_RADIUS));
  assign ny_s = signed'({2'b00, cy}) + signed'(OFS_W'(row))
              - signed'(OFS_W'(pdga_pkg::NBR_RADIUS));
  assign nx = (nx_s < 0) ? '0 :
              (nx_s > signed'({2'b00, cols_m1})) ? cols_m1 : nx_s[DIM_W-1:0];
  assign ny = (ny_s < 0) ? '0 :
              (ny_s > signed'({2'b00, rows_m1})) ? rows_m1 : ny_s[DIM_W-1:0];
  // cell numbers wrap modulo the store depth on the low address bits
  assign nbr_addr = rowbase + IDX_W'(nx);

  assign shown     = (count > pdga_pkg::CNT_W'(pdga_pkg::SHOWN_MAX)) ?
                     pdga_pkg::SHOWN_MAX : pdga_pkg::OUT_IDX_W'(count);
  assign last_cell = (col == NBR_LAST) && (row == NBR_LAST);

  assign nbr_valid = mem_rdata[pdga_pkg::ENTRY_W-1];
  assign sx        = mem_rdata[PT_W-1:0];
  assign sy        = mem_rdata[2*PT_W-1:PT_W];
  assign adx       = (px >= sx) ? px - sx : sx - px;
  assign ady_c     = (py >= sy) ? py - sy : sy - py;
  // two squares of 19-bit values stay below 2^39, so the sum never saturates
  assign dist_sum  = pdga_pkg::DIST_W'(sq_x) + pdga_pkg::DIST_W'(prod[2*PT_W-1:0]);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_CX: begin
        mul_a = px;
        mul_b = inv_cell_size;
      end
      S_CY: begin
        mul_a = py;
        mul_b = inv_cell_size;
      end
      S_OWNM: begin
        mul_a = pdga_pkg::MUL_A_W'(q_row);
        mul_b = pdga_pkg::MUL_B_W'(cols_eff);
      end
      S_ROW: begin
        mul_a = pdga_pkg::MUL_A_W'(ny);
        mul_b = pdga_pkg::MUL_B_W'(cols_eff);
      end
      S_DX: begin
        mul_a = adx;
        mul_b = pdga_pkg::MUL_B_W'(adx);
      end
      S_DY: begin
        mul_a = ady;
        mul_b = pdga_pkg::MUL_B_W'(ady);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = nbr_addr;
    mem_wdata = '0;
    case (state)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_addr  = own;
        mem_wdata = {1'b1, py, px};
      end
      default: begin
        mem_addr = nbr_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      clr_report    <= 1'b0;
      count         <= '0;
      strobe        <= 1'b0;
      rect_width    <= pdga_pkg::RECT_RESET;
      rect_height   <= pdga_pkg::RECT_RESET;
      min_dist_sq   <= '0;
      inv_cell_size <= pdga_pkg::INV_RESET;
      grid_cols     <= pdga_pkg::DIM_RESET;
      grid_rows     <= pdga_pkg::DIM_RESET;
    end else begin
      strobe <= 1'b0;

      if (wr_en) begin
        case (wr_index)
          pdga_pkg::REG_RECT_WIDTH:  rect_width    <= wr_data[PT_W-1:0];
          pdga_pkg::REG_RECT_HEIGHT: rect_height   <= wr_data[PT_W-1:0];
          pdga_pkg::REG_MIN_DIST_SQ: min_dist_sq   <= wr_data[pdga_pkg::DIST_W-1:0];
          pdga_pkg::REG_INV_CELL:    inv_cell_size <= wr_data[pdga_pkg::INV_W-1:0];
          pdga_pkg::REG_GRID_COLS:   grid_cols     <= wr_data[DIM_W-1:0];
          pdga_pkg::REG_GRID_ROWS:   grid_rows     <= wr_data[DIM_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            if (kind) begin
              state      <= S_CLR;
              clr_addr   <= '0;
              clr_report <= 1'b1;
              count      <= '0;
            end else begin
              x_raw <= cand_x;
              y_raw <= cand_y;
              state <= S_RANGE;
            end
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(GRID_CELLS - 1)) begin
            state <= S_IDLE;
            if (clr_report) begin
              strobe      <= 1'b1;
              status      <= pdga_pkg::ST_CLEARED;
              point_index <= '0;
              cell_index  <= '0;
            end
          end
        end
        S_RANGE: begin
          if (outside) begin
            strobe      <= 1'b1;
            status      <= pdga_pkg::ST_OUTSIDE;
            point_index <= shown;
            cell_index  <= '0;
            state       <= S_IDLE;
          end else begin
            state <= S_CX;
          end
        end
        S_CX: begin
          state <= S_CY;
        end
        S_CY: begin
          cx    <= q_col;
          state <= S_OWNM;
        end
        S_OWNM: begin
          cy    <= q_row;
          state <= S_OWNA;
        end
        S_OWNA: begin
          own   <= IDX_W'(prod) + IDX_W'(cx);
          row   <= '0;
          col   <= '0;
          state <= S_ROW;
        end
        S_ROW: begin
          state <= S_RB;
        end
        S_RB: begin
          rowbase <= IDX_W'(prod);
          state   <= S_RD;
        end
        S_RD: begin
          state <= S_DX;
        end
        S_DX: begin
          if (nbr_valid) begin
            ady   <= ady_c;
            state <= S_DY;
          end else if (last_cell) begin
            state <= S_WR;
          end else if (col == NBR_LAST) begin
            col   <= '0;
            row   <= row + pdga_pkg::NBR_W'(1);
            state <= S_ROW;
          end else begin
            col   <= col + pdga_pkg::NBR_W'(1);
            state <= S_RD;
          end
        end
        S_DY: begin
          sq_x  <= prod[2*PT_W-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (dist_sum < min_dist_sq) begin
            strobe      <= 1'b1;
            status      <= pdga_pkg::ST_TOO_CLOSE;
            point_index <= shown;
            cell_index  <= pdga_pkg::OUT_IDX_W'(own);
            state       <= S_IDLE;
          end else if (last_cell) begin
            state <= S_WR;
          end else if (col == NBR_LAST) begin
            col   <= '0;
            row   <= row + pdga_pkg::NBR_W'(1);
            state <= S_ROW;
          end else begin
            col   <= col + pdga_pkg::NBR_W'(1);
            state <= S_RD;
          end
        end
        S_WR: begin
          if (count != pdga_pkg::CNT_MAX) begin
            count <= count + pdga_pkg::CNT_W'(1);
          end
          strobe      <= 1'b1;
          status      <= pdga_pkg::ST_ACCEPTED;
          point_index <= shown;
          cell_index  <= pdga_pkg::OUT_IDX_W'(own);
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result always closes the transaction and frees the block
  a_strobe_frees: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy && $past(busy))
    else $error("result strobe while block still busy");

  // an accepted transaction makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not start work");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status == pdga_pkg::ST_CLEARED |-> point_index == '0 && cell_index == '0)
    else $error("clear result with nonzero indexes");

  a_outside_cell: assert property (@(posedge clk) disable iff (rst)
    strobe && status == pdga_pkg::ST_OUTSIDE |-> cell_index == '0)
    else $error("outside result with nonzero cell index");

  // the count moves only by one on an accepted point or to zero on a clear
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> count == '0 || $past(state) == S_WR)
    else $error("point count changed outside write or clear");
`endif

endmodule

FILE: rtl/core/pdga_mul.sv
module pdga_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pdga_pkg::MUL_A_W-1:0]  a,
  input  logic [pdga_pkg::MUL_B_W-1:0]  b,
  output logic [pdga_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= pdga_pkg::PROD_W'(a) * pdga_pkg::PROD_W'(b);
    end
  end

endmodule

FILE: rtl/core/pdga_grid_mem.sv
module pdga_grid_mem #(
  parameter int DEPTH  = pdga_pkg::GRID_CELLS_DEF,
  parameter int ADDR_W = $clog2(pdga_pkg::GRID_CELLS_DEF)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [pdga_pkg::ENTRY_W-1:0]  wdata,
  output logic [pdga_pkg::ENTRY_W-1:0]  rdata
);

  logic [pdga_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: test/tb_poisson_disk_grid_acceptor.sv
module tb_poisson_disk_grid_acceptor;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_N = pdga_pkg::GRID_CELLS_DEF;
  localparam longint DIST_SAT = 64'h00FF_FFFF_FFFF;
  localparam int PILE_POINTS = 60;

  typedef struct packed {
    logic [pdga_pkg::STATUS_W-1:0]  status;
    logic [pdga_pkg::OUT_IDX_W-1:0] point_index;
    logic [pdga_pkg::OUT_IDX_W-1:0] cell_index;
  } verdict_t;

  // Grid acceptor model plus the queue of verdicts still owed by the block.
  class acceptor_scoreboard;
    bit [pdga_pkg::PT_W-1:0]   rect_w;
    bit [pdga_pkg::PT_W-1:0]   rect_h;
    bit [pdga_pkg::DIST_W-1:0] min_sq;
    bit [pdga_pkg::INV_W-1:0]  inv;
    bit [pdga_pkg::DIM_W-1:0]  cols_reg;
    bit [pdga_pkg::DIM_W-1:0]  rows_reg;
    bit                        cell_used [GRID_N];
    bit [pdga_pkg::PT_W-1:0]   px [GRID_N];
    bit [pdga_pkg::PT_W-1:0]   py [GRID_N];
    bit [pdga_pkg::CNT_W-1:0]  count;
    verdict_t                  verdict_q [$];
    int                        recent_x [$];
    int                        recent_y [$];
    int                        errors;
    int                        n_status [4];

    function new();
      rect_w   = pdga_pkg::RECT_RESET;
      rect_h   = pdga_pkg::RECT_RESET;
      min_sq   = '0;
      inv      = pdga_pkg::INV_RESET;
      cols_reg = pdga_pkg::DIM_RESET;
      rows_reg = pdga_pkg::DIM_RESET;
      foreach (cell_used[i]) cell_used[i] = 1'b0;
      count  = '0;
      errors = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void set_reg(logic [pdga_pkg::CFG_IDX_W-1:0] idx,
                          logic [pdga_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        pdga_pkg::REG_RECT_WIDTH:  rect_w   = val[pdga_pkg::PT_W-1:0];
        pdga_pkg::REG_RECT_HEIGHT: rect_h   = val[pdga_pkg::PT_W-1:0];
        pdga_pkg::REG_MIN_DIST_SQ: min_sq   = val[pdga_pkg::DIST_W-1:0];
        pdga_pkg::REG_INV_CELL:    inv      = val[pdga_pkg::INV_W-1:0];
        pdga_pkg::REG_GRID_COLS:   cols_reg = val[pdga_pkg::DIM_W-1:0];
        pdga_pkg::REG_GRID_ROWS:   rows_reg = val[pdga_pkg::DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint cell_of(longint c, longint lim);
      longint q;
      q = (c * longint'(inv)) >> pdga_pkg::INV_SHIFT;
      if (q > lim - 1) q = lim - 1;
      return q;
    endfunction

    function void note_candidate(logic k, logic signed [19:0] xin, logic signed [19:0] yin);
      verdict_t v;
      longint x, y, cols, rows, cx, cy, nx, ny, ddx, ddy, s;
      int own, idx;
      bit near;
      logic [pdga_pkg::OUT_IDX_W-1:0] shown;
      cols  = (cols_reg == 0) ? 1 : longint'(cols_reg);
      rows  = (rows_reg == 0) ? 1 : longint'(rows_reg);
      shown = (count > pdga_pkg::CNT_W'(pdga_pkg::SHOWN_MAX)) ?
              pdga_pkg::SHOWN_MAX : count[pdga_pkg::OUT_IDX_W-1:0];
      if (k) begin
        foreach (cell_used[i]) cell_used[i] = 1'b0;
        count = '0;
        v = '{pdga_pkg::ST_CLEARED, '0, '0};
        verdict_q = {verdict_q, v};
        return;
      end
      x = longint'(xin);
      y = longint'(yin);
      if (x < 0 || y < 0 || x > longint'(rect_w) || y > longint'(rect_h)) begin
        v = '{pdga_pkg::ST_OUTSIDE, shown, '0};
        verdict_q = {verdict_q, v};
        return;
      end
      cx   = cell_of(x, cols);
      cy   = cell_of(y, rows);
      own  = int'((cy * cols + cx) % GRID_N);
      near = 1'b0;
      for (int i = -pdga_pkg::NBR_RADIUS; i <= pdga_pkg::NBR_RADIUS; i++) begin
        for (int j = -pdga_pkg::NBR_RADIUS; j <= pdga_pkg::NBR_RADIUS; j++) begin
          nx = cx + i;
          ny = cy + j;
          if (nx < 0) nx = 0;
          if (nx > cols - 1) nx = cols - 1;
          if (ny < 0) ny = 0;
          if (ny > rows - 1) ny = rows - 1;
          idx = int'((ny * cols + nx) % GRID_N);
          if (cell_used[idx]) begin
            ddx = x - longint'(px[idx]);
            ddy = y - longint'(py[idx]);
            s = ddx * ddx + ddy * ddy;
            if (s > DIST_SAT) s = DIST_SAT;
            if (s < longint'(min_sq)) near = 1'b1;
          end
        end
      end
      v.cell_index  = own[pdga_pkg::OUT_IDX_W-1:0];
      v.point_index = shown;
      if (near) begin
        v.status = pdga_pkg::ST_TOO_CLOSE;
      end else begin
        v.status = pdga_pkg::ST_ACCEPTED;
        cell_used[own] = 1'b1;
        px[own] = x[pdga_pkg::PT_W-1:0];
        py[own] = y[pdga_pkg::PT_W-1:0];
        if (count < pdga_pkg::CNT_MAX) count++;
        recent_x = {recent_x, int'(x)};
        recent_y = {recent_y, int'(y)};
        if (recent_x.size() > 32) begin
          void'(recent_x.pop_front());
          void'(recent_y.pop_front());
        end
      end
      verdict_q = {verdict_q, v};
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [pdga_pkg::STATUS_W-1:0] st,
                               logic [pdga_pkg::OUT_IDX_W-1:0] pi,
                               logic [pdga_pkg::OUT_IDX_W-1:0] ci);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none, actual status %0d index %0d cell %0d",
                   $time, st, pi, ci);
        return;
      end
      v = verdict_q.pop_front();
      n_status[v.status]++;
      compare_field("status", 32'(v.status), 32'(st));
      compare_field("point_index", 32'(v.point_index), 32'(pi));
      compare_field("cell_index", 32'(v.cell_index), 32'(ci));
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic                                 kind = 1'b0;
  logic signed [19:0]                   cand_x = '0;
  logic signed [19:0]                   cand_y = '0;
  logic                                 wr_en = 1'b0;
  logic [pdga_pkg::CFG_IDX_W-1:0]       wr_index = '0;
  logic [pdga_pkg::CFG_DATA_W-1:0]      wr_data = '0;
  logic                                 strobe;
  logic [pdga_pkg::STATUS_W-1:0]        status;
  logic [pdga_pkg::OUT_IDX_W-1:0]       point_index;
  logic [pdga_pkg::OUT_IDX_W-1:0]       cell_index;

  acceptor_scoreboard sb;
  int idle_pct = 0;
  int spread = 256;
  int n_settings = 0;

  poisson_disk_grid_acceptor u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .cand_x      (cand_x),
    .cand_y      (cand_y),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .strobe      (strobe),
    .status      (status),
    .point_index (point_index),
    .cell_index  (cell_index)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) sb.check_result(status, point_index, cell_index);
  end

  initial begin
    #40ms;
    $display("%0t: timeout, %0d results outstanding", $time, sb.verdict_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic sender_gap();
    if (idle_pct != 0 && $urandom_range(0, 19) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 130)) @(posedge clk);
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_item(input logic k, input logic signed [19:0] x,
                           input logic signed [19:0] y);
    sender_gap();
    start  <= 1'b1;
    kind   <= k;
    cand_x <= x;
    cand_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_candidate(k, x, y);
  endtask

  // Hold off until every verdict is back and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pdga_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pdga_pkg::CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(input logic [pdga_pkg::PT_W-1:0] w,
                              input logic [pdga_pkg::PT_W-1:0] h,
                              input logic [pdga_pkg::DIST_W-1:0] md,
                              input logic [pdga_pkg::INV_W-1:0] iv,
                              input logic [pdga_pkg::DIM_W-1:0] c,
                              input logic [pdga_pkg::DIM_W-1:0] r);
    wait_idle();
    write_reg(pdga_pkg::REG_RECT_WIDTH, pdga_pkg::CFG_DATA_W'(w));
    write_reg(pdga_pkg::REG_RECT_HEIGHT, pdga_pkg::CFG_DATA_W'(h));
    write_reg(pdga_pkg::REG_MIN_DIST_SQ, pdga_pkg::CFG_DATA_W'(md));
    write_reg(pdga_pkg::REG_INV_CELL, pdga_pkg::CFG_DATA_W'(iv));
    write_reg(pdga_pkg::REG_GRID_COLS, pdga_pkg::CFG_DATA_W'(c));
    write_reg(pdga_pkg::REG_GRID_ROWS, pdga_pkg::CFG_DATA_W'(r));
    wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic pick_settings();
    int mode, cs, rr, w, h, c, r;
    longint md;
    int iv;
    mode = $urandom_range(0, 3);
    case (mode)
      1: begin
        w  = $urandom_range(0, 524287);
        h  = $urandom_range(0, 524287);
        md = {$urandom, $urandom} & DIST_SAT;
        iv = $urandom_range(0, 16777215);
        c  = $urandom_range(0, 4096);
        r  = $urandom_range(0, 4096);
        spread = w / 8 + 1;
      end
      2: begin
        w  = $urandom_range(0, 8000);
        h  = $urandom_range(0, 8000);
        md = $urandom_range(0, 4000000);
        iv = $urandom_range(0, 16777215);
        c  = $urandom_range(0, 3);
        r  = $urandom_range(0, 3);
        spread = 2048;
      end
      default: begin
        // spacing r = cell * sqrt(2), as the sampling scheme sizes its grid
        cs = $urandom_range(64, 2048);
        rr = cs * 181 / 128;
        w  = $urandom_range(cs, cs * 40);
        h  = $urandom_range(cs, cs * 40);
        if (w > 524287) w = 524287;
        if (h > 524287) h = 524287;
        iv = (1 << pdga_pkg::INV_SHIFT) / cs;
        c  = w / cs + 1;
        r  = h / cs + 1;
        md = longint'(rr) * rr;
        if (mode == 3) md = $urandom_range(0, 1) ? DIST_SAT : 0;
        spread = 2 * rr;
      end
    endcase
    apply_config(pdga_pkg::PT_W'(w), pdga_pkg::PT_W'(h), pdga_pkg::DIST_W'(md),
                 pdga_pkg::INV_W'(iv), pdga_pkg::DIM_W'(c), pdga_pkg::DIM_W'(r));
  endtask

  function automatic int pick_edge(int lim);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return lim;
      2: return lim + 1;
      3: return -1;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  task automatic random_item();
    int r, w, h, bx, by, k;
    w = int'(sb.rect_w);
    h = int'(sb.rect_h);
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_item(1'b1, 20'($urandom), 20'($urandom));
    end else if (r < 10) begin
      send_item(1'b0, 20'($urandom), 20'($urandom));
    end else if (r < 16) begin
      send_item(1'b0, 20'(pick_edge(w)), 20'(pick_edge(h)));
    end else begin
      if (sb.recent_x.size() > 0 && $urandom_range(0, 2) != 0) begin
        k  = $urandom_range(0, sb.recent_x.size() - 1);
        bx = sb.recent_x[k] + $urandom_range(0, 2 * spread) - spread;
        by = sb.recent_y[k] + $urandom_range(0, 2 * spread) - spread;
      end else begin
        bx = $urandom_range(0, w);
        by = $urandom_range(0, h);
      end
      if (bx < 0) bx = 0;
      if (bx > w) bx = w;
      if (by < 0) by = 0;
      if (by > h) by = h;
      send_item(1'b0, 20'(bx), 20'(by));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // reset settings: corners of the coordinate range, negative coordinates
    send_item(1'b0, 20'sd0, 20'sd0);
    send_item(1'b0, 20'sd524287, 20'sd524287);
    send_item(1'b0, 20'sh8_0000, 20'sh8_0000);
    send_item(1'b0, -20'sd1, 20'sd5);
    send_item(1'b0, 20'sd5, -20'sd1);
    send_item(1'b1, 20'($urandom), 20'($urandom));

    // spacing of two units, one-unit cells: distance just below and at the limit
    apply_config(19'd2560, 19'd2560, 40'd262144, 24'd65536, 13'd10, 13'd10);
    send_item(1'b0, 20'sd1000, 20'sd1000);
    send_item(1'b0, 20'sd1511, 20'sd1000);
    send_item(1'b0, 20'sd1512, 20'sd1000);
    send_item(1'b0, 20'sd2560, 20'sd2560);
    send_item(1'b0, 20'sd2561, 20'sd0);
    send_item(1'b0, 20'sd0, 20'sd2561);
    send_item(1'b0, 20'sd1010, 20'sd1010);

    // zero-sized rectangle and grid, zero reciprocal, widest spacing
    apply_config(19'd0, 19'd0, DIST_SAT[pdga_pkg::DIST_W-1:0], 24'd0, 13'd0, 13'd0);
    send_item(1'b1, 20'($urandom), 20'($urandom));
    send_item(1'b0, 20'sd0, 20'sd0);
    send_item(1'b0, 20'sd0, 20'sd0);
    send_item(1'b0, 20'sd1, 20'sd0);

    // grid wider than the store, largest reciprocal, overwrite of a cell
    apply_config(pdga_pkg::RECT_RESET, pdga_pkg::RECT_RESET, 40'd0, 24'hFF_FFFF,
                 13'd4096, 13'd4096);
    send_item(1'b0, 20'sd100, 20'sd7);
    send_item(1'b0, 20'sd100, 20'sd9000);
    send_item(1'b0, 20'sd524287, 20'sd3);
    apply_config(pdga_pkg::RECT_RESET, pdga_pkg::RECT_RESET,
                 DIST_SAT[pdga_pkg::DIST_W-1:0], 24'hFF_FFFF, 13'd4096, 13'd4096);
    send_item(1'b0, 20'sd100, 20'sd0);
    send_item(1'b0, 20'sd300000, 20'sd300000);

    // pile many points into one cell, each overwriting the last
    apply_config(pdga_pkg::RECT_RESET, pdga_pkg::RECT_RESET, 40'd0, pdga_pkg::INV_RESET,
                 pdga_pkg::DIM_RESET, pdga_pkg::DIM_RESET);
    send_item(1'b1, 20'($urandom), 20'($urandom));
    for (int n = 0; n < PILE_POINTS; n++)
      send_item(1'b0, 20'(32 * 256 + $urandom_range(0, 255)),
                20'(32 * 256 + $urandom_range(0, 255)));
    send_item(1'b0, -20'sd3, 20'sd3);
    apply_config(pdga_pkg::RECT_RESET, pdga_pkg::RECT_RESET, DIST_SAT[pdga_pkg::DIST_W-1:0],
                 pdga_pkg::INV_RESET, pdga_pkg::DIM_RESET, pdga_pkg::DIM_RESET);
    send_item(1'b0, 20'sd8300, 20'sd8300);
    send_item(1'b1, 20'($urandom), 20'($urandom));

    for (int seg = 0; seg < 3; seg++) begin
      idle_pct = (seg == 0) ? 6 : (seg == 1) ? 87 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        pick_settings();
        if ($urandom_range(0, 1) != 0) send_item(1'b1, 20'($urandom), 20'($urandom));
        for (int n = 0; n < 100; n++) begin
          if (n == 50) wait_idle();
          random_item();
        end
      end
    end

    wait_idle();
    repeat (150) @(posedge clk);
    $display("covered %0d accepted, %0d outside, %0d too close, %0d clear transactions",
             sb.n_status[pdga_pkg::ST_ACCEPTED], sb.n_status[pdga_pkg::ST_OUTSIDE],
             sb.n_status[pdga_pkg::ST_TOO_CLOSE], sb.n_status[pdga_pkg::ST_CLEARED]);
    $display("over %0d register settings, %0d points piled into one cell", n_settings,
             PILE_POINTS);
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pdga_pkg.sv
rtl/core/pdga_mul.sv
rtl/core/pdga_grid_mem.sv
rtl/core/poisson_disk_grid_acceptor.sv
test/tb_poisson_disk_grid_acceptor.sv
